// ----- src/grcw_pkg.sv -----
// Shared constants, command and status types and helpers of the grid ray cell walk.
package grcw_pkg;

  // Grid limits and result cap
  localparam int MAX_CELLS_X = 8;
  localparam int MAX_CELLS_Z = 8;
  localparam int RESULT_CAP  = 64;

  // Field and register widths
  localparam int CS_W     = 13;
  localparam int CNT_W    = 4;
  localparam int COL_W    = $clog2(MAX_CELLS_X);
  localparam int ROW_W    = $clog2(MAX_CELLS_Z);
  localparam int IDX_W    = 6;
  localparam int N_W      = $clog2(RESULT_CAP) + 1;
  localparam int IN_POS_W = 24;
  localparam int DIR_W    = 16;
  localparam int LEN_W    = 24;
  localparam int FRAC     = 8;
  localparam int DIR_FRAC = 14;

  // Internal arithmetic widths
  localparam int POS_W   = 27;
  localparam int E_W     = CS_W + FRAC;
  localparam int ZE_W    = E_W + CNT_W;
  localparam int PROD_W  = DIR_W + LEN_W + 1;
  localparam int NUM_W   = 42;
  localparam int MAG_W   = NUM_W - 1;
  localparam int DEN_W   = E_W + 1;
  localparam int DMAG_W  = E_W;
  localparam int CQ_W    = 21;
  localparam int LONG_STEPS  = MAG_W;
  localparam int SHORT_STEPS = POS_W;
  localparam int STEP_W  = $clog2(LONG_STEPS + 1);

  // Configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam logic [1:0] REG_CELL_SIZE    = 2'd0;
  localparam logic [1:0] REG_CELLS_ACROSS = 2'd1;
  localparam logic [1:0] REG_CELLS_DOWN   = 2'd2;
  localparam logic [CS_W-1:0]  CELL_SIZE_RST = 13'd128;
  localparam logic [CNT_W-1:0] CELLS_RST     = 4'd8;

  // Multiplier operand choice
  typedef enum logic [1:0] {
    MUL_TX, MUL_TZ, MUL_X0, MUL_X1
  } mul_sel_e;

  // Divider operand choice and destination
  typedef enum logic [2:0] {
    DIV_SX, DIV_TX, DIV_SZ, DIV_TZ, DIV_T0, DIV_T1, DIV_X0, DIV_X1
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_go;
    mul_sel_e mul_sel;
    logic     div_go;
    div_sel_e div_sel;
    logic     span_init;
    logic     row_first;
    logic     row_set;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic span_path;
    logic last;
    logic x_end;
  } sts_t;

  // Clamp a signed cell coordinate into [0, n-1]
  function automatic logic [CNT_W-1:0] clamp_cnt(input logic signed [CQ_W-1:0] q,
                                                  input logic [CNT_W-1:0] n);
    logic signed [CQ_W-1:0] n_s;
    n_s = $signed(CQ_W'(n));
    if (q < 0) begin
      return '0;
    end else if (q >= n_s) begin
      return n - CNT_W'(1);
    end else begin
      return q[CNT_W-1:0];
    end
  endfunction

endpackage

// ----- src/grid_ray_cell_walk.sv -----
// Top level of the grid ray cell walk: configuration registers, controller and datapath.
//
// Channel        | Handshake               | Payload
// ---------------+-------------------------+------------------------------------------
// ray request    | start high, busy low    | start_x_i, start_z_i, dir_x_i, dir_z_i,
//                |                         | ray_length_i
// cell result    | result_valid_o, 1 cycle | cell_index_o, last_cell_o
// configuration  | APB write, pready tied  | paddr, pwdata / prdata
//
// Sequence: the accepting edge is followed by set-up (two multiplies, four 27-step
// divisions of the shared divider, one decision state), then per row of a multi-row
// walk two long divisions, two multiply and short-division pairs and a row set-up,
// then the row's cells are emitted; each cell is registered and reaches the ports in
// the cycle after its emit. The single divider, one quotient bit a cycle, sets the pace.
// Reset clears the controller and loads cell_size 128 and an 8 by 8 grid.
// Results cannot be held off; busy drops as the last cell is registered, so the next
// request may be taken while that cell is still on the ports.
module grid_ray_cell_walk (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Ray request
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [grcw_pkg::IN_POS_W-1:0]  start_x_i,
  input  logic signed [grcw_pkg::IN_POS_W-1:0]  start_z_i,
  input  logic signed [grcw_pkg::DIR_W-1:0]     dir_x_i,
  input  logic signed [grcw_pkg::DIR_W-1:0]     dir_z_i,
  input  logic [grcw_pkg::LEN_W-1:0]            ray_length_i,
  // Cell results
  output logic                                  result_valid_o,
  output logic [grcw_pkg::IDX_W-1:0]            cell_index_o,
  output logic                                  last_cell_o,
  // Configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [grcw_pkg::APB_AW-1:0]           paddr,
  input  logic [grcw_pkg::APB_DW-1:0]           pwdata,
  output logic [grcw_pkg::APB_DW-1:0]           prdata,
  output logic                                  pready
);
  import grcw_pkg::*;

  logic [CS_W-1:0]  cell_size_q;
  logic [CNT_W-1:0] cells_across_q, cells_down_q;
  logic [1:0]       reg_idx;
  logic             wr_en;
  logic [CS_W-1:0]  cs_eff;
  logic [E_W-1:0]   edge_len;
  logic [CNT_W-1:0] nx, nz;
  cmd_t             cmd;
  sts_t             sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q    <= CELL_SIZE_RST;
      cells_across_q <= CELLS_RST;
      cells_down_q   <= CELLS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CELL_SIZE:    cell_size_q    <= pwdata[CS_W-1:0];
        REG_CELLS_ACROSS: cells_across_q <= pwdata[CNT_W-1:0];
        REG_CELLS_DOWN:   cells_down_q   <= pwdata[CNT_W-1:0];
        default:          cell_size_q    <= cell_size_q;
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (reg_idx)
      REG_CELL_SIZE:    prdata = APB_DW'(cell_size_q);
      REG_CELLS_ACROSS: prdata = APB_DW'(cells_across_q);
      REG_CELLS_DOWN:   prdata = APB_DW'(cells_down_q);
      default:          prdata = '0;
    endcase
  end

  // Effective cell edge in Q.8 and grid counts
  assign cs_eff   = (cell_size_q == '0) ? CS_W'(1) : cell_size_q;
  assign edge_len = {cs_eff, FRAC'(0)};
  assign nx = (cells_across_q == '0) ? CNT_W'(1)
            : (cells_across_q > CNT_W'(MAX_CELLS_X)) ? CNT_W'(MAX_CELLS_X) : cells_across_q;
  assign nz = (cells_down_q == '0) ? CNT_W'(1)
            : (cells_down_q > CNT_W'(MAX_CELLS_Z)) ? CNT_W'(MAX_CELLS_Z) : cells_down_q;

  grcw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  grcw_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .start_x_i      (start_x_i),
    .start_z_i      (start_z_i),
    .dir_x_i        (dir_x_i),
    .dir_z_i        (dir_z_i),
    .ray_length_i   (ray_length_i),
    .edge_i         (edge_len),
    .nx_i           (nx),
    .nz_i           (nz),
    .cell_index_o   (cell_index_o),
    .last_cell_o    (last_cell_o),
    .result_valid_o (result_valid_o)
  );

endmodule

// ----- src/grcw_div.sv -----
// Shared restoring divider with floor rounding, one quotient bit per cycle.
module grcw_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                go_i,
  input  logic                                short_i,
  input  logic signed [grcw_pkg::NUM_W-1:0]   num_i,
  input  logic signed [grcw_pkg::DEN_W-1:0]   den_i,
  output logic                                done_o,
  output logic signed [grcw_pkg::NUM_W-1:0]   quo_o
);
  import grcw_pkg::*;

  logic [DMAG_W-1:0] rem_q, rem_d;
  logic [MAG_W-1:0]  quo_q, quo_d;
  logic [DMAG_W-1:0] den_q;
  logic              neg_q;
  logic [STEP_W-1:0] cnt_q;
  logic              run_q, done_q;

  logic [MAG_W-1:0]  num_mag;
  logic [DMAG_W-1:0] den_mag;
  logic [DMAG_W+1:0] trial;
  logic              qbit;
  logic [NUM_W-1:0]  quo_ext;

  // Operand magnitudes
  assign num_mag = MAG_W'(num_i[NUM_W-1] ? -num_i : num_i);
  assign den_mag = DMAG_W'(den_i[DEN_W-1] ? -den_i : den_i);

  // One restoring step
  assign trial = {1'b0, rem_q, quo_q[MAG_W-1]} - {2'b00, den_q};
  assign qbit  = ~trial[DMAG_W+1];
  assign rem_d = qbit ? trial[DMAG_W-1:0] : {rem_q[DMAG_W-2:0], quo_q[MAG_W-1]};
  assign quo_d = {quo_q[MAG_W-2:0], qbit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == STEP_W'(1));
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= short_i ? STEP_W'(SHORT_STEPS) : STEP_W'(LONG_STEPS);
      end else if (run_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // Datapath registers of the divider
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      rem_q <= '0;
      quo_q <= short_i ? (num_mag << (MAG_W - SHORT_STEPS)) : num_mag;
      den_q <= den_mag;
      neg_q <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // Floor correction for unlike signs
  assign quo_ext = {1'b0, quo_q};
  assign quo_o   = !neg_q ? $signed(quo_ext)
                 : (rem_q != '0) ? $signed(~quo_ext) : $signed(-quo_ext);
  assign done_o  = done_q;

endmodule

// ----- src/grcw_dpath.sv -----
// Datapath: ray registers, shared multiplier, divider, row and column walk, result register.
module grcw_dpath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  grcw_pkg::cmd_t                        cmd_i,
  output grcw_pkg::sts_t                        sts_o,
  input  logic signed [grcw_pkg::IN_POS_W-1:0]  start_x_i,
  input  logic signed [grcw_pkg::IN_POS_W-1:0]  start_z_i,
  input  logic signed [grcw_pkg::DIR_W-1:0]     dir_x_i,
  input  logic signed [grcw_pkg::DIR_W-1:0]     dir_z_i,
  input  logic [grcw_pkg::LEN_W-1:0]            ray_length_i,
  input  logic [grcw_pkg::E_W-1:0]              edge_i,
  input  logic [grcw_pkg::CNT_W-1:0]            nx_i,
  input  logic [grcw_pkg::CNT_W-1:0]            nz_i,
  output logic [grcw_pkg::IDX_W-1:0]            cell_index_o,
  output logic                                  last_cell_o,
  output logic                                  result_valid_o
);
  import grcw_pkg::*;

  // Ray registers
  logic signed [IN_POS_W-1:0] sx_q, sz_q;
  logic signed [DIR_W-1:0]    dx_q, dz_q;
  logic [LEN_W-1:0]           len_q;
  logic signed [POS_W-1:0]    tx_q, tz_q, mx_q;
  logic signed [CQ_W-1:0]     qsx_q, qtx_q, qsz_q, qtz_q;
  logic [LEN_W-1:0]           t0_q, t1_q;
  logic [COL_W-1:0]           xa_q, xb_q, x_q, xe_q;
  logic [ROW_W-1:0]           z_q, z1_q;
  logic [IDX_W-1:0]           row_q;
  logic [N_W-1:0]             n_q;
  logic                       span_q;
  div_sel_e                   dsel_q;
  logic [IDX_W-1:0]           res_idx_q;
  logic                       res_last_q, res_valid_q;

  // Combinational helpers
  logic signed [POS_W-1:0]    sx_w, sz_w, e_s, zlo, zhi, p0, p1, pdiff;
  logic signed [POS_W-1:0]    ge_s, ze_s, ze1_s;
  logic [ZE_W-1:0]            ze, ze1, ge;
  logic                       edge0, edge1, same_x, row_last, x_end, last;
  logic signed [DIR_W-1:0]    mul_a;
  logic [LEN_W-1:0]           mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [POS_W-1:0]    mres;
  logic signed [NUM_W-1:0]    div_num, div_q;
  logic signed [DEN_W-1:0]    div_den;
  logic                       div_short, div_done;
  logic signed [CQ_W-1:0]     q_cell, zlo_q, zhi_q;
  logic [LEN_W-1:0]           t_clamp;
  logic [COL_W-1:0]           sa, sb, ra, rb;
  logic [CNT_W-1:0]           clx_q, cly_q, cl_sa, cl_sb, cl_zs, cl_z0, cl_z1;

  assign sx_w = POS_W'(sx_q);
  assign sz_w = POS_W'(sz_q);
  assign e_s  = $signed(POS_W'(edge_i));

  // Row bounds along z
  assign zlo   = (sz_w < tz_q) ? sz_w : tz_q;
  assign zhi   = (sz_w < tz_q) ? tz_q : sz_w;
  assign zlo_q = (sz_w < tz_q) ? qsz_q : qtz_q;
  assign zhi_q = (sz_w < tz_q) ? qtz_q : qsz_q;
  assign ze    = ZE_W'(z_q) * ZE_W'(edge_i);
  assign ze1   = ze + ZE_W'(edge_i);
  assign ge    = ZE_W'(nz_i) * ZE_W'(edge_i);
  assign ze_s  = $signed(POS_W'(ze));
  assign ze1_s = $signed(POS_W'(ze1));
  assign ge_s  = $signed(POS_W'(ge));

  assign row_last = (z_q == z1_q);
  // Edge rows take the ray's own end when it runs outside the grid
  assign edge0 = ((zlo < 0) && (z_q == '0)) || ((zlo >= ge_s) && row_last);
  assign edge1 = ((zhi < 0) && (z_q == '0)) || ((zhi >= ge_s) && row_last);
  assign p0    = edge0 ? zlo : ze_s;
  assign p1    = edge1 ? (zhi + e_s) : ze1_s;
  assign pdiff = ((cmd_i.div_sel == DIV_T1) ? p1 : p0) - sz_w;

  // Shared multiplier: dir * length or dir * t, floored to Q.8, plus start
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_TX:  begin mul_a = dx_q; mul_b = len_q; end
      MUL_TZ:  begin mul_a = dz_q; mul_b = len_q; end
      MUL_X0:  begin mul_a = dx_q; mul_b = t0_q;  end
      MUL_X1:  begin mul_a = dx_q; mul_b = t1_q;  end
      default: begin mul_a = dx_q; mul_b = len_q; end
    endcase
  end
  assign prod = PROD_W'(mul_a) * $signed({1'b0, mul_b});
  assign mres = prod[DIR_FRAC +: POS_W] + ((cmd_i.mul_sel == MUL_TZ) ? sz_w : sx_w);

  // Divider operand selection
  always_comb begin
    div_num   = NUM_W'(sx_w);
    div_den   = $signed(DEN_W'(edge_i));
    div_short = 1'b1;
    unique case (cmd_i.div_sel)
      DIV_SX: div_num = NUM_W'(sx_w);
      DIV_TX: div_num = NUM_W'(tx_q);
      DIV_SZ: div_num = NUM_W'(sz_w);
      DIV_TZ: div_num = NUM_W'(tz_q);
      DIV_T0, DIV_T1: begin
        div_num   = NUM_W'(pdiff) <<< DIR_FRAC;
        div_den   = DEN_W'(dz_q);
        div_short = 1'b0;
      end
      DIV_X0, DIV_X1: div_num = NUM_W'(mx_q);
      default: div_num = NUM_W'(sx_w);
    endcase
  end

  grcw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (cmd_i.div_go),
    .short_i (div_short),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  // Quotient post-processing
  assign q_cell = CQ_W'(div_q);
  assign clx_q  = clamp_cnt(q_cell, nx_i);
  assign t_clamp = (div_q < 0) ? '0
                 : (div_q > $signed(NUM_W'(len_q))) ? len_q : div_q[LEN_W-1:0];

  // Single-row span bounds
  assign same_x = (qsx_q == qtx_q);
  assign cl_sa  = clamp_cnt(qsx_q, nx_i);
  assign cl_sb  = clamp_cnt(qtx_q, nx_i);
  assign cl_zs  = clamp_cnt(qsz_q, nz_i);
  assign cl_z0  = clamp_cnt(zlo_q, nz_i);
  assign cl_z1  = clamp_cnt(zhi_q, nz_i);
  assign cly_q  = cl_zs;
  assign sa     = cl_sa[COL_W-1:0];
  assign sb     = same_x ? sa : cl_sb[COL_W-1:0];
  assign ra     = (xa_q < xb_q) ? xa_q : xb_q;
  assign rb     = (xa_q < xb_q) ? xb_q : xa_q;

  assign x_end = (x_q == xe_q);
  assign last  = (n_q == N_W'(RESULT_CAP - 1)) || (x_end && (span_q || row_last));

  assign sts_o.div_done  = div_done;
  assign sts_o.span_path = (qsz_q == qtz_q) || (dz_q == '0);
  assign sts_o.last      = last;
  assign sts_o.x_end     = x_end;

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sx_q  <= start_x_i;
      sz_q  <= start_z_i;
      dx_q  <= dir_x_i;
      dz_q  <= dir_z_i;
      len_q <= ray_length_i;
    end
    if (cmd_i.mul_go) begin
      unique case (cmd_i.mul_sel)
        MUL_TX:  tx_q <= mres;
        MUL_TZ:  tz_q <= mres;
        MUL_X0, MUL_X1: mx_q <= mres;
        default: mx_q <= mres;
      endcase
    end
    if (cmd_i.div_go) begin
      dsel_q <= cmd_i.div_sel;
    end
    if (div_done) begin
      unique case (dsel_q)
        DIV_SX: qsx_q <= q_cell;
        DIV_TX: qtx_q <= q_cell;
        DIV_SZ: qsz_q <= q_cell;
        DIV_TZ: qtz_q <= q_cell;
        DIV_T0: t0_q  <= t_clamp;
        DIV_T1: t1_q  <= t_clamp;
        DIV_X0: xa_q  <= clx_q[COL_W-1:0];
        DIV_X1: xb_q  <= clx_q[COL_W-1:0];
        default: qsx_q <= q_cell;
      endcase
    end
    // Span along one row
    if (cmd_i.span_init) begin
      x_q    <= (sa < sb) ? sa : sb;
      xe_q   <= (sa < sb) ? sb : sa;
      row_q  <= IDX_W'(cly_q[ROW_W-1:0]) * IDX_W'(nx_i);
      n_q    <= '0;
      span_q <= 1'b1;
    end
    // First and last row of a multi-row walk
    if (cmd_i.row_first) begin
      z_q    <= cl_z0[ROW_W-1:0];
      z1_q   <= cl_z1[ROW_W-1:0];
      n_q    <= '0;
      span_q <= 1'b0;
    end
    if (cmd_i.row_set) begin
      x_q   <= ra;
      xe_q  <= rb;
      row_q <= IDX_W'(z_q) * IDX_W'(nx_i);
    end
    // One cell per cycle
    if (cmd_i.emit) begin
      res_idx_q  <= row_q + IDX_W'(x_q);
      res_last_q <= last;
      n_q        <= n_q + N_W'(1);
      if (!x_end) begin
        x_q <= x_q + COL_W'(1);
      end else if (!last) begin
        z_q <= z_q + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
    end
  end

  assign cell_index_o   = res_idx_q;
  assign last_cell_o    = res_last_q;
  assign result_valid_o = res_valid_q;

endmodule

// ----- src/grcw_ctrl.sv -----
// Controller: sequences multiplications, divisions, row set-up and cell output.
module grcw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  grcw_pkg::sts_t sts_i,
  output grcw_pkg::cmd_t cmd_o
);
  import grcw_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_MTX, S_MTZ, S_DSX, S_DTX, S_DSZ, S_DTZ, S_DECIDE,
    S_DT0, S_DT1, S_MX0, S_DX0, S_MX1, S_DX1, S_ROWSET, S_EMIT, S_WAIT
  } state_e;

  state_e state_q, ret_q;

  // Command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_sel   = MUL_TX;
    cmd_o.div_sel   = DIV_SX;
    unique case (state_q)
      S_IDLE:   cmd_o.load = start_i;
      S_MTX:    begin cmd_o.mul_go = 1'b1; cmd_o.mul_sel = MUL_TX; end
      S_MTZ:    begin cmd_o.mul_go = 1'b1; cmd_o.mul_sel = MUL_TZ; end
      S_DSX:    begin cmd_o.div_go = 1'b1; cmd_o.div_sel = DIV_SX; end
      S_DTX:    begin cmd_o.div_go = 1'b1; cmd_o.div_sel = DIV_TX; end
      S_DSZ:    begin cmd_o.div_go = 1'b1; cmd_o.div_sel = DIV_SZ; end
      S_DTZ:    begin cmd_o.div_go = 1'b1; cmd_o.div_sel = DIV_TZ; end
      S_DECIDE: begin
        cmd_o.span_init = sts_i.span_path;
        cmd_o.row_first = !sts_i.span_path;
      end
      S_DT0:    begin cmd_o.div_go = 1'b1; cmd_o.div_sel = DIV_T0; end
      S_DT1:    begin cmd_o.div_go = 1'b1; cmd_o.div_sel = DIV_T1; end
      S_MX0:    begin cmd_o.mul_go = 1'b1; cmd_o.mul_sel = MUL_X0; end
      S_DX0:    begin cmd_o.div_go = 1'b1; cmd_o.div_sel = DIV_X0; end
      S_MX1:    begin cmd_o.mul_go = 1'b1; cmd_o.mul_sel = MUL_X1; end
      S_DX1:    begin cmd_o.div_go = 1'b1; cmd_o.div_sel = DIV_X1; end
      S_ROWSET: cmd_o.row_set = 1'b1;
      S_EMIT:   cmd_o.emit = 1'b1;
      S_WAIT:   cmd_o.emit = 1'b0;
      default:  cmd_o.emit = 1'b0;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  // State register; a division parks in S_WAIT and returns to ret_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE:   if (start_i) state_q <= S_MTX;
        S_MTX:    state_q <= S_MTZ;
        S_MTZ:    state_q <= S_DSX;
        S_DSX:    begin ret_q <= S_DTX;    state_q <= S_WAIT; end
        S_DTX:    begin ret_q <= S_DSZ;    state_q <= S_WAIT; end
        S_DSZ:    begin ret_q <= S_DTZ;    state_q <= S_WAIT; end
        S_DTZ:    begin ret_q <= S_DECIDE; state_q <= S_WAIT; end
        S_DECIDE: state_q <= sts_i.span_path ? S_EMIT : S_DT0;
        S_DT0:    begin ret_q <= S_DT1;    state_q <= S_WAIT; end
        S_DT1:    begin ret_q <= S_MX0;    state_q <= S_WAIT; end
        S_MX0:    state_q <= S_DX0;
        S_DX0:    begin ret_q <= S_MX1;    state_q <= S_WAIT; end
        S_MX1:    state_q <= S_DX1;
        S_DX1:    begin ret_q <= S_ROWSET; state_q <= S_WAIT; end
        S_ROWSET: state_q <= S_EMIT;
        S_EMIT: begin
          if (sts_i.last) begin
            state_q <= S_IDLE;
          end else if (sts_i.x_end) begin
            state_q <= S_DT0;
          end
        end
        S_WAIT:   if (sts_i.div_done) state_q <= ret_q;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/grcw_checker.sv -----
// Scoreboard of the grid ray cell walk: tracks register writes, predicts cells and checks them.
module grcw_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic signed [grcw_pkg::IN_POS_W-1:0] start_x_i,
  input  logic signed [grcw_pkg::IN_POS_W-1:0] start_z_i,
  input  logic signed [grcw_pkg::DIR_W-1:0]    dir_x_i,
  input  logic signed [grcw_pkg::DIR_W-1:0]    dir_z_i,
  input  logic [grcw_pkg::LEN_W-1:0]           ray_length_i,
  input  logic                                 result_valid_o,
  input  logic [grcw_pkg::IDX_W-1:0]           cell_index_o,
  input  logic                                 last_cell_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic                                 pready,
  input  logic [grcw_pkg::APB_AW-1:0]          paddr,
  input  logic [grcw_pkg::APB_DW-1:0]          pwdata,
  output int                                   mismatches,
  output int                                   outstanding
);
  import grcw_pkg::*;

  // Shadow copy of the configuration registers
  logic [CS_W-1:0]  cell_size_q;
  logic [CNT_W-1:0] across_q;
  logic [CNT_W-1:0] down_q;

  // Cells still to come, oldest first
  logic [IDX_W-1:0] cell_q[$];
  logic             last_q[$];

  assign outstanding = cell_q.size();

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b != 0) && ((a < 0) != (b < 0))) q--;
    return q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint grid_count(logic [CNT_W-1:0] v, longint lim);
    if (v == 0) return 1;
    if (longint'(v) > lim) return lim;
    return longint'(v);
  endfunction

  // Queue one row span, honouring the cap on cells per ray
  function automatic void push_span(longint row, longint a, longint b, ref int n);
    longint c;
    for (c = a; c <= b && n < RESULT_CAP; c++) begin
      cell_q = {cell_q, IDX_W'(row + c)};
      last_q = {last_q, 1'b0};
      n++;
    end
  endfunction

  // Work out the cells a ray crosses, row by row
  function automatic void walk_ray(longint sx, longint sz, longint dx, longint dz, longint len);
    longint e, nx, nz, tx, tz, x0, x1, zlo, zhi, gend, z0, z1, z, p0, p1, t0, t1, s;
    int n;
    n = 0;
    e = (cell_size_q == 0 ? 1 : longint'(cell_size_q)) * 256;
    nx = grid_count(across_q, MAX_CELLS_X);
    nz = grid_count(down_q, MAX_CELLS_Z);
    tx = sx + fdiv(dx * len, 1 << DIR_FRAC);
    tz = sz + fdiv(dz * len, 1 << DIR_FRAC);
    if (fdiv(sz, e) == fdiv(tz, e) || dz == 0) begin
      // single row: one span
      x0 = clip(fdiv(sx, e), 0, nx - 1);
      x1 = clip(fdiv(tx, e), 0, nx - 1);
      if (fdiv(sx, e) == fdiv(tx, e)) x1 = x0;
      if (x1 < x0) begin s = x0; x0 = x1; x1 = s; end
      push_span(clip(fdiv(sz, e), 0, nz - 1) * nx, x0, x1, n);
    end else begin
      zlo = sz < tz ? sz : tz;
      zhi = sz < tz ? tz : sz;
      gend = nz * e;
      z0 = clip(fdiv(zlo, e), 0, nz - 1);
      z1 = clip(fdiv(zhi, e), 0, nz - 1);
      for (z = z0; z <= z1 && n < RESULT_CAP; z++) begin
        p0 = z * e;
        p1 = (z + 1) * e;
        // edge rows take the ray's own end when it runs outside the grid
        if ((zlo < 0 && z == 0) || (zlo >= gend && z == z1)) p0 = zlo;
        if ((zhi < 0 && z == 0) || (zhi >= gend && z == z1)) p1 = zhi + e;
        t0 = clip(fdiv((p0 - sz) * (1 << DIR_FRAC), dz), 0, len);
        t1 = clip(fdiv((p1 - sz) * (1 << DIR_FRAC), dz), 0, len);
        x0 = clip(fdiv(fdiv(dx * t0, 1 << DIR_FRAC) + sx, e), 0, nx - 1);
        x1 = clip(fdiv(fdiv(dx * t1, 1 << DIR_FRAC) + sx, e), 0, nx - 1);
        if (x1 < x0) begin s = x0; x0 = x1; x1 = s; end
        push_span(z * nx, x0, x1, n);
      end
    end
    if (n > 0) last_q[last_q.size() - 1] = 1'b1;
  endfunction

  // Register writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= CELL_SIZE_RST;
      across_q    <= CELLS_RST;
      down_q      <= CELLS_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_CELL_SIZE:    cell_size_q <= pwdata[CS_W-1:0];
        REG_CELLS_ACROSS: across_q    <= pwdata[CNT_W-1:0];
        REG_CELLS_DOWN:   down_q      <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Predict on each accepted request, compare each cell as it leaves
  initial mismatches = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        if (cell_q.size() == 0) begin
          $error("unexpected cell: cell_index %0d last_cell %0b", cell_index_o, last_cell_o);
          mismatches++;
        end else begin
          if (cell_index_o !== cell_q[0]) begin
            $error("cell_index: expected %0d, actual %0d", cell_q[0], cell_index_o);
            mismatches++;
          end
          if (last_cell_o !== last_q[0]) begin
            $error("last_cell: expected %0b, actual %0b", last_q[0], last_cell_o);
            mismatches++;
          end
          void'(cell_q.pop_front());
          void'(last_q.pop_front());
        end
      end
      if (start && !busy)
        walk_ray(longint'(start_x_i), longint'(start_z_i), longint'(dir_x_i),
                 longint'(dir_z_i), longint'(ray_length_i));
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top of the grid ray cell walk: clock, reset, ray and register stimulus, verdict.
module tb;
  import grcw_pkg::*;

  localparam int LIMIT = 1000000;

  logic                       clk_i, rst_ni;
  logic                       start, busy;
  logic signed [IN_POS_W-1:0] start_x_i, start_z_i;
  logic signed [DIR_W-1:0]    dir_x_i, dir_z_i;
  logic [LEN_W-1:0]           ray_length_i;
  logic                       result_valid_o, last_cell_o;
  logic [IDX_W-1:0]           cell_index_o;
  logic                       psel, penable, pwrite, pready;
  logic [APB_AW-1:0]          paddr;
  logic [APB_DW-1:0]          pwdata, prdata;
  int                         mismatches, outstanding;
  int                         cycles;

  // Settings of the generator, following what was written to the block
  longint edge_q8, cols, rows;
  int     idle_pct;

  grid_ray_cell_walk dut (.*);

  grcw_checker u_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [APB_DW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Program the grid and keep the generator in step
  task automatic set_grid(int cs, int nx, int nz);
    reg_write(REG_CELL_SIZE, cs);
    reg_write(REG_CELLS_ACROSS, nx);
    reg_write(REG_CELLS_DOWN, nz);
    edge_q8 = (cs == 0 ? 1 : cs) * 256;
    cols = nx == 0 ? 1 : (nx > MAX_CELLS_X ? MAX_CELLS_X : nx);
    rows = nz == 0 ? 1 : (nz > MAX_CELLS_Z ? MAX_CELLS_Z : nz);
  endtask

  // Hold off until every predicted cell has come out
  task automatic drain();
    do @(negedge clk_i); while (outstanding != 0 || busy);
  endtask

  // Issue one ray request and wait for it to be taken
  task automatic send_ray(longint sx, longint sz, longint dx, longint dz, longint len);
    start        <= 1'b1;
    start_x_i    <= IN_POS_W'(sx);
    start_z_i    <= IN_POS_W'(sz);
    dir_x_i      <= DIR_W'(dx);
    dir_z_i      <= DIR_W'(dz);
    ray_length_i <= LEN_W'(len);
    forever begin
      @(negedge clk_i);
      if (!busy) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic longint rand_dir();
    return longint'($urandom_range(32768)) - 16384;
  endfunction

  // Mostly rays in and around the grid, some raw noise and degenerate rays
  task automatic random_ray();
    longint span, sx, sz, len;
    int     kind;
    kind = $urandom_range(99);
    span = (cols > rows ? cols : rows) * edge_q8 + 2 * edge_q8;
    if (span > 32'hFFFF_FFF) span = 32'hFFFF_FFF;
    sx = longint'($urandom_range(0, span)) - edge_q8;
    sz = longint'($urandom_range(0, span)) - edge_q8;
    len = $urandom_range(0, (4 * edge_q8 > 24'hFFFFFF) ? 24'hFFFFFF : 4 * edge_q8);
    if (kind < 70)
      send_ray(sx, sz, rand_dir(), rand_dir(), len);
    else if (kind < 85)
      send_ray(longint'($signed(24'($urandom))), longint'($signed(24'($urandom))),
               rand_dir(), rand_dir(), $urandom_range(0, 24'hFFFFFF));
    else if (kind < 92)
      send_ray(sx, sz, rand_dir(), 0, len);
    else
      send_ray(sx, sz, 0, rand_dir(), $urandom_range(1) ? 0 : len);
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    start_x_i = '0;
    start_z_i = '0;
    dir_x_i = '0;
    dir_z_i = '0;
    ray_length_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    edge_q8 = 128 * 256;
    cols = 8;
    rows = 8;
    idle_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rays on the reset grid (cell edge 32768 in Q.8)
    send_ray(1000, 1000, 16384, 16384, 0);                 // zero length
    send_ray(40000, 40000, 0, 0, 24'hFFFFFF);              // zero direction
    send_ray(1000, 1000, 8000, 8000, 512);                 // inside one cell
    send_ray(1000, 40000, 16384, 0, 200000);               // row span, flat
    send_ray(200000, 40000, -16384, 100, 150000);          // row span, leftwards
    send_ray(1000, 1000, 11585, 11585, 250000);            // diagonal across the grid
    send_ray(250000, 250000, -11585, -11585, 250000);      // diagonal, falling
    send_ray(50000, -100000, 3000, 16384, 400000);         // from below the grid
    send_ray(50000, 400000, -3000, -16384, 400000);        // from above the grid
    send_ray(-32768, -32768, 16384, 60, 24'hFFFFFF);       // shallow: one row, full
    send_ray(-8388608, -8388608, 16384, 16384, 24'hFFFFFF);
    send_ray(8388607, 8388607, -16384, -16384, 24'hFFFFFF);
    send_ray(8388607, -8388608, -16384, 16384, 24'hFFFFFF);
    send_ray(-1, -1, 1, 1, 1);
    send_ray(100000, 0, 0, 16384, 32768);                  // vertical onto a row boundary
    send_ray(0, 100000, -1, -16384, 24'h800000);
    send_ray(262143, 262143, 16384, -16384, 10);
    send_ray(65536, 65536, -16384, 16383, 65536);

    // Phases of random rays under several grids and sender idling
    for (int ph = 0; ph < 6; ph++) begin
      start <= 1'b0;
      drain();
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1 ? 50 : 19);
      case (ph)
        1: set_grid(1, 1, 1);
        2: set_grid(4096, 8, 8);
        3: set_grid(0, 0, 0);
        4: set_grid(16, 15, 12);
        5: begin
          set_grid(7, 3, 5);
          reg_write(2'd3, 32'hFFFF_FFFF);                   // unmapped, ignored
        end
        default: ;
      endcase
      @(posedge clk_i);
      for (int i = 0; i < 14; i++) begin
        random_ray();
        // once in each phase, let the walk finish before the next ray
        if (i == 7) begin
          start <= 1'b0;
          drain();
          @(posedge clk_i);
        end
      end
    end
    start <= 1'b0;
    drain();
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      if (outstanding != 0) $error("%0d cells never came out", outstanding);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
